[hw/rtl/nac_pkg.sv]
// ----------------------------------------------------------------------------
// nac_pkg
// Shared widths, codes, register indexes and reset values for the
// neighbor address cache.
// ----------------------------------------------------------------------------
package nac_pkg;

  // field widths
  localparam int NET_W      = 32;
  localparam int LINK_W     = 16;
  localparam int VLAN_W     = 8;
  localparam int AGE_W      = 8;
  localparam int PCNT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // action codes
  localparam logic ACT_LEARN  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PINNED_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIN0_NET_ADDR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIN0_LINK_ADDR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIN0_VLAN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIN1_NET_ADDR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PIN1_LINK_ADDR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PIN1_VLAN      = 3'd6;

  // register reset values
  localparam logic [PCNT_W-1:0] PINNED_COUNT_RST = 2'd2;
  localparam logic [NET_W-1:0]  PIN0_NET_RST     = 32'h0a01_0101;
  localparam logic [LINK_W-1:0] PIN0_LINK_RST    = 16'h0001;
  localparam logic [VLAN_W-1:0] PIN0_VLAN_RST    = 8'd1;
  localparam logic [NET_W-1:0]  PIN1_NET_RST     = 32'h0a01_0201;
  localparam logic [LINK_W-1:0] PIN1_LINK_RST    = 16'h0002;
  localparam logic [VLAN_W-1:0] PIN1_VLAN_RST    = 8'd2;

  // saturation point of the age counter
  localparam logic [AGE_W-1:0] AGE_SAT = 8'hFF;

  // one dynamic slot as kept in the slot memory
  typedef struct packed {
    logic [NET_W-1:0]  net_addr;
    logic [LINK_W-1:0] link_addr;
    logic [VLAN_W-1:0] vlan;
    logic [AGE_W-1:0]  age;
  } slot_t;

endpackage

[hw/rtl/neighbor_address_cache_core.sv]
// ----------------------------------------------------------------------------
// neighbor_address_cache_core
// Neighbor cache mapping network addresses to link addresses and vlans,
// with two pinned entries from registers and aging dynamic slots in a
// synchronous memory.
// ----------------------------------------------------------------------------
//
// channel   | handshake               | words
// ----------+-------------------------+--------------------------------------
// command   | start, busy             | action, net_addr, link_addr, vlan_tag
// result    | done (one-cycle strobe) | hit, found_link_addr, found_vlan
// config    | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// A lookup of address 0, any learn of address 0 and a lookup that hits a
// pinned entry answer in the cycle after acceptance. Anything else scans
// the slot memory one slot a cycle (one read port, one word per cycle);
// a learn that matches or a lookup hit can stop the scan before the last
// slot. busy stays high during the scan; a new command is taken in the
// cycle that done is shown. Synchronous reset empties all slots at once
// through per-slot valid bits. The receiver cannot stall.
//
module neighbor_address_cache_core #(
  parameter int DYNAMIC_SLOTS = 16,
  parameter int AGE_LIMIT     = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // command
  input  logic                             start,
  output logic                             busy,
  input  logic                             action,
  input  logic [nac_pkg::NET_W-1:0]        net_addr,
  input  logic [nac_pkg::LINK_W-1:0]       link_addr,
  input  logic [nac_pkg::VLAN_W-1:0]       vlan_tag,
  // result
  output logic                             done,
  output logic                             hit,
  output logic [nac_pkg::LINK_W-1:0]       found_link_addr,
  output logic [nac_pkg::VLAN_W-1:0]       found_vlan,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nac_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import nac_pkg::*;

  localparam int IDX_W = (DYNAMIC_SLOTS > 1) ? $clog2(DYNAMIC_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DYNAMIC_SLOTS - 1);
  localparam logic [AGE_W-1:0] AGE_LIM  = AGE_W'(AGE_LIMIT);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  // configuration registers
  logic [PCNT_W-1:0] pinned_count;
  logic [NET_W-1:0]  pin0_net;
  logic [LINK_W-1:0] pin0_link;
  logic [VLAN_W-1:0] pin0_vlan;
  logic [NET_W-1:0]  pin1_net;
  logic [LINK_W-1:0] pin1_link;
  logic [VLAN_W-1:0] pin1_vlan;

  // control
  logic             state;
  logic [IDX_W-1:0] p;

  // captured command
  logic              act_q;
  logic [NET_W-1:0]  na_q;
  logic [LINK_W-1:0] la_q;
  logic [VLAN_W-1:0] vl_q;

  // learn victim tracking
  logic             have_free, have_free_next;
  logic [IDX_W-1:0] free_slot, free_slot_next;
  logic [IDX_W-1:0] old_slot, old_slot_next;
  logic [AGE_W-1:0] max_age, max_age_next;

  // slot memory and valid bits
  slot_t                    mem [DYNAMIC_SLOTS];
  logic [DYNAMIC_SLOTS-1:0] vld;
  slot_t                    rd_data;
  logic                     rd_vld;
  logic [IDX_W-1:0]         rd_addr;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  slot_t                    wr_data;

  // scan step results
  logic              last;
  logic [NET_W-1:0]  cur_net;
  logic              match;
  logic [AGE_W-1:0]  age_inc;
  logic              fin;
  logic              fin_hit;
  logic [LINK_W-1:0] fin_link;
  logic [VLAN_W-1:0] fin_vlan;

  // pinned entry compare
  logic accept;
  logic pin0_hit;
  logic pin1_hit;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign pin0_hit  = (pinned_count != '0) && (pin0_net == net_addr);
  assign pin1_hit  = pinned_count[1] && (pin1_net == net_addr);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pinned_count <= PINNED_COUNT_RST;
      pin0_net     <= PIN0_NET_RST;
      pin0_link    <= PIN0_LINK_RST;
      pin0_vlan    <= PIN0_VLAN_RST;
      pin1_net     <= PIN1_NET_RST;
      pin1_link    <= PIN1_LINK_RST;
      pin1_vlan    <= PIN1_VLAN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PINNED_COUNT:   pinned_count <= cfg_data[PCNT_W-1:0];
        REG_PIN0_NET_ADDR:  pin0_net     <= cfg_data[NET_W-1:0];
        REG_PIN0_LINK_ADDR: pin0_link    <= cfg_data[LINK_W-1:0];
        REG_PIN0_VLAN:      pin0_vlan    <= cfg_data[VLAN_W-1:0];
        REG_PIN1_NET_ADDR:  pin1_net     <= cfg_data[NET_W-1:0];
        REG_PIN1_LINK_ADDR: pin1_link    <= cfg_data[LINK_W-1:0];
        REG_PIN1_VLAN:      pin1_vlan    <= cfg_data[VLAN_W-1:0];
        default: ;
      endcase
    end
  end

  // read address: slot 0 while idle, then the slot after the one in hand
  assign last    = (p == LAST_IDX);
  assign rd_addr = (state == S_SCAN && !last) ? p + IDX_W'(1) : '0;

  // slot memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // valid bits, cleared by reset so every slot reads empty
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld <= vld[rd_addr];
  end

  // per-slot decode of the word just read
  assign cur_net = rd_vld ? rd_data.net_addr : '0;
  assign match   = (cur_net == na_q);
  assign age_inc = (rd_data.age == AGE_SAT) ? rd_data.age : rd_data.age + AGE_W'(1);

  // scan step: learn tracking, aging write-back, finish decision
  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = p;
    wr_data        = '{net_addr: na_q, link_addr: la_q, vlan: vl_q, age: '0};
    fin            = 1'b0;
    fin_hit        = 1'b0;
    fin_link       = '0;
    fin_vlan       = '0;
    have_free_next = have_free;
    free_slot_next = free_slot;
    old_slot_next  = old_slot;
    max_age_next   = max_age;
    if (state == S_SCAN) begin
      if (act_q == ACT_LEARN) begin
        fin_hit = 1'b1;
        if (match) begin
          wr_en = 1'b1;
          fin   = 1'b1;
        end else begin
          if (cur_net == '0) begin
            if (!have_free) begin
              have_free_next = 1'b1;
              free_slot_next = p;
            end
          end else if (rd_data.age > max_age) begin
            max_age_next  = rd_data.age;
            old_slot_next = p;
          end
          // end of scan: fill the first empty slot or replace the oldest
          if (last) begin
            wr_en   = 1'b1;
            wr_addr = have_free_next ? free_slot_next : old_slot_next;
            fin     = 1'b1;
          end
        end
      end else begin
        if (match) begin
          wr_en   = 1'b1;
          wr_data = '{net_addr: cur_net, link_addr: rd_data.link_addr,
                      vlan: rd_data.vlan, age: age_inc};
          if (age_inc >= AGE_LIM) begin
            // expired entry: empty the slot and keep searching
            wr_data.net_addr = '0;
            fin = last;
          end else begin
            fin      = 1'b1;
            fin_hit  = 1'b1;
            fin_link = rd_data.link_addr;
            fin_vlan = rd_data.vlan;
          end
        end else begin
          fin = last;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      p     <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            p <= '0;
            if (net_addr == '0 || (action == ACT_LOOKUP && (pin0_hit || pin1_hit))) begin
              done <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (fin) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            p <= p + IDX_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // command capture, tracker and result words
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      act_q     <= action;
      na_q      <= net_addr;
      la_q      <= link_addr;
      vl_q      <= vlan_tag;
      have_free <= 1'b0;
      free_slot <= '0;
      old_slot  <= '0;
      max_age   <= '0;
      if (net_addr == '0) begin
        hit             <= (action == ACT_LEARN);
        found_link_addr <= '0;
        found_vlan      <= '0;
      end else if (pin0_hit) begin
        hit             <= 1'b1;
        found_link_addr <= pin0_link;
        found_vlan      <= pin0_vlan;
      end else begin
        hit             <= 1'b1;
        found_link_addr <= pin1_link;
        found_vlan      <= pin1_vlan;
      end
    end else if (state == S_SCAN) begin
      have_free <= have_free_next;
      free_slot <= free_slot_next;
      old_slot  <= old_slot_next;
      max_age   <= max_age_next;
      if (fin) begin
        hit             <= fin_hit;
        found_link_addr <= fin_link;
        found_vlan      <= fin_vlan;
      end
    end
  end

`ifndef SYNTHESIS
  // a result follows either an immediate answer or the scan
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(state == S_SCAN)))
    else $error("result strobe without a command in flight");

  // learn always answers hit
  assert property (@(posedge clk) disable iff (rst)
    (done && act_q == ACT_LEARN) |-> hit)
    else $error("learn answered a miss");

  // a miss carries zero words
  assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (found_link_addr == '0 && found_vlan == '0))
    else $error("miss with nonzero fields");

  // the memory is written only while scanning
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_SCAN))
    else $error("slot write outside the scan");

  // scan index never passes the last slot
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (p <= LAST_IDX))
    else $error("scan index out of range");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the neighbor address cache. Commands go in from a
// queue through a clocked driver. A predictor keeps its own copy of the
// pinned entries and the dynamic slots and works out the answer to every
// accepted command. A clocked monitor compares each done word with the
// oldest expected answer. Register writes happen only while the block is
// idle, between phases. Each random phase uses its own pinned setup, address
// pool and sender gap rate.
// ----------------------------------------------------------------------------
module tb_top;
  import nac_pkg::*;

  localparam int DYNAMIC_SLOTS = 16;
  localparam int AGE_LIMIT     = 16;
  localparam int POOL_MAX      = 24;
  localparam int RANDOM_ITEMS  = 642;
  localparam int CYCLE_LIMIT   = 400000;

  // index past the last register, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic              action;
    logic [NET_W-1:0]  net_addr;
    logic [LINK_W-1:0] link_addr;
    logic [VLAN_W-1:0] vlan_tag;
  } cmd_t;

  typedef struct packed {
    logic              hit;
    logic [LINK_W-1:0] link_addr;
    logic [VLAN_W-1:0] vlan;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  start     = 1'b0;
  logic                  busy;
  logic                  action    = ACT_LEARN;
  logic [NET_W-1:0]      net_addr  = '0;
  logic [LINK_W-1:0]     link_addr = '0;
  logic [VLAN_W-1:0]     vlan_tag  = '0;
  logic                  done;
  logic                  hit;
  logic [LINK_W-1:0]     found_link_addr;
  logic [VLAN_W-1:0]     found_vlan;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  cmd_t    cmd_q[$];
  answer_t answer_q[$];
  int      errors      = 0;
  int      cycle_count = 0;
  int      send_gap_pct = 0;

  // predictor copy of registers and slots
  logic [PCNT_W-1:0] pinned_cnt = PINNED_COUNT_RST;
  logic [NET_W-1:0]  pin_net[2]  = '{PIN0_NET_RST, PIN1_NET_RST};
  logic [LINK_W-1:0] pin_link[2] = '{PIN0_LINK_RST, PIN1_LINK_RST};
  logic [VLAN_W-1:0] pin_vlan[2] = '{PIN0_VLAN_RST, PIN1_VLAN_RST};
  logic [NET_W-1:0]  cache_net[DYNAMIC_SLOTS]  = '{default: '0};
  logic [LINK_W-1:0] cache_link[DYNAMIC_SLOTS] = '{default: '0};
  logic [VLAN_W-1:0] cache_vlan[DYNAMIC_SLOTS] = '{default: '0};
  logic [AGE_W-1:0]  cache_age[DYNAMIC_SLOTS]  = '{default: '0};

  logic [NET_W-1:0] addr_pool[POOL_MAX];
  int               pool_n = POOL_MAX;

  neighbor_address_cache_core #(
    .DYNAMIC_SLOTS(DYNAMIC_SLOTS),
    .AGE_LIMIT    (AGE_LIMIT)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .net_addr       (net_addr),
    .link_addr      (link_addr),
    .vlan_tag       (vlan_tag),
    .done           (done),
    .hit            (hit),
    .found_link_addr(found_link_addr),
    .found_vlan     (found_vlan),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // learn: update a match, else take the first empty slot, else the oldest
  function automatic void learn_mapping(cmd_t c);
    bit               have_free = 1'b0;
    int               free_slot = 0;
    int               old_slot = 0;
    logic [AGE_W-1:0] max_age = '0;
    int               victim;
    if (c.net_addr == '0) return;
    for (int s = 0; s < DYNAMIC_SLOTS; s++) begin
      if (cache_net[s] == c.net_addr) begin
        cache_link[s] = c.link_addr;
        cache_vlan[s] = c.vlan_tag;
        cache_age[s]  = '0;
        return;
      end
      if (cache_net[s] == '0) begin
        if (!have_free) begin
          have_free = 1'b1;
          free_slot = s;
        end
      end else if (cache_age[s] > max_age) begin
        max_age  = cache_age[s];
        old_slot = s;
      end
    end
    victim = have_free ? free_slot : old_slot;
    cache_net[victim]  = c.net_addr;
    cache_link[victim] = c.link_addr;
    cache_vlan[victim] = c.vlan_tag;
    cache_age[victim]  = '0;
  endfunction

  // lookup: pinned entries first, then dynamic slots with aging
  function automatic answer_t resolve_address(logic [NET_W-1:0] na);
    answer_t a = '0;
    int      pc = (pinned_cnt > 2) ? 2 : int'(pinned_cnt);
    if (na == '0) return a;
    for (int p = 0; p < pc; p++) begin
      if (pin_net[p] == na) begin
        a.hit       = 1'b1;
        a.link_addr = pin_link[p];
        a.vlan      = pin_vlan[p];
        return a;
      end
    end
    for (int s = 0; s < DYNAMIC_SLOTS; s++) begin
      if (cache_net[s] != na) continue;
      if (cache_age[s] < AGE_SAT) cache_age[s] = cache_age[s] + 1'b1;
      if (cache_age[s] >= AGE_LIMIT) begin
        cache_net[s] = '0;
        continue;
      end
      a.hit       = 1'b1;
      a.link_addr = cache_link[s];
      a.vlan      = cache_vlan[s];
      return a;
    end
    return a;
  endfunction

  function automatic answer_t predict_answer(cmd_t c);
    answer_t a = '0;
    if (c.action == ACT_LEARN) begin
      learn_mapping(c);
      a.hit = 1'b1;
    end else begin
      a = resolve_address(c.net_addr);
    end
    return a;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PINNED_COUNT:   pinned_cnt  = data[PCNT_W-1:0];
      REG_PIN0_NET_ADDR:  pin_net[0]  = data[NET_W-1:0];
      REG_PIN0_LINK_ADDR: pin_link[0] = data[LINK_W-1:0];
      REG_PIN0_VLAN:      pin_vlan[0] = data[VLAN_W-1:0];
      REG_PIN1_NET_ADDR:  pin_net[1]  = data[NET_W-1:0];
      REG_PIN1_LINK_ADDR: pin_link[1] = data[LINK_W-1:0];
      REG_PIN1_VLAN:      pin_vlan[1] = data[VLAN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic cmd_t make_cmd(logic act, logic [NET_W-1:0] na,
                                    logic [LINK_W-1:0] la, logic [VLAN_W-1:0] vl);
    cmd_t c;
    c.action    = act;
    c.net_addr  = na;
    c.link_addr = la;
    c.vlan_tag  = vl;
    return c;
  endfunction

  function automatic logic [NET_W-1:0] pool_addr();
    return addr_pool[$urandom_range(pool_n - 1)];
  endfunction

  // pool mixes current pinned addresses, extremes and random addresses
  function automatic void build_pool(int n);
    pool_n = n;
    addr_pool[0] = pin_net[0];
    addr_pool[1] = pin_net[1];
    addr_pool[2] = 32'hFFFF_FFFF;
    addr_pool[3] = 32'h0000_0001;
    addr_pool[4] = 32'h8000_0000;
    for (int i = 5; i < POOL_MAX; i++) addr_pool[i] = $urandom;
  endfunction

  // random traffic: mostly learn and lookup on the pool, some aging bursts
  function automatic void queue_random_traffic(int count);
    int               made = 0;
    int               pick;
    int               burst;
    logic [NET_W-1:0] na;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        cmd_q.push_back(make_cmd(ACT_LEARN, pool_addr(),
                                 LINK_W'($urandom), VLAN_W'($urandom)));
        made++;
      end else if (pick < 75) begin
        cmd_q.push_back(make_cmd(ACT_LOOKUP, pool_addr(),
                                 LINK_W'($urandom), VLAN_W'($urandom)));
        made++;
      end else if (pick < 85) begin
        na    = pool_addr();
        burst = $urandom_range(10, 20);
        for (int i = 0; i < burst; i++) begin
          cmd_q.push_back(make_cmd(ACT_LOOKUP, na,
                                   LINK_W'($urandom), VLAN_W'($urandom)));
        end
        made += burst;
      end else begin
        na = ($urandom_range(7) == 0) ? '0 : NET_W'($urandom);
        cmd_q.push_back(make_cmd(1'($urandom_range(1)), na,
                                 LINK_W'($urandom), VLAN_W'($urandom)));
        made++;
      end
    end
  endfunction

  task automatic wait_drained();
    while (cmd_q.size() != 0 || answer_q.size() != 0) @(posedge clk);
    repeat (DYNAMIC_SLOTS + 2) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // stimulus sequence
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: zero address, pinned hits, extremes, learn over pinned, aging out
    cmd_q.push_back(make_cmd(ACT_LOOKUP, '0, 16'hFFFF, 8'hFF));
    cmd_q.push_back(make_cmd(ACT_LEARN, '0, 16'hABCD, 8'h5A));
    cmd_q.push_back(make_cmd(ACT_LOOKUP, PIN0_NET_RST, '0, '0));
    cmd_q.push_back(make_cmd(ACT_LOOKUP, PIN1_NET_RST, '0, '0));
    cmd_q.push_back(make_cmd(ACT_LEARN, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF));
    cmd_q.push_back(make_cmd(ACT_LEARN, 32'h0000_0001, 16'h0000, 8'h00));
    cmd_q.push_back(make_cmd(ACT_LEARN, PIN0_NET_RST, 16'h1234, 8'h77));
    cmd_q.push_back(make_cmd(ACT_LOOKUP, PIN0_NET_RST, '0, '0));
    cmd_q.push_back(make_cmd(ACT_LOOKUP, 32'h0000_0001, '0, '0));
    cmd_q.push_back(make_cmd(ACT_LOOKUP, 32'h1234_5678, '0, '0));
    for (int i = 0; i < AGE_LIMIT; i++) begin
      cmd_q.push_back(make_cmd(ACT_LOOKUP, 32'hFFFF_FFFF, '0, '0));
    end
    wait_drained();

    // one pinned entry, all-ones pin 0, dropped write to the unused index
    write_register(REG_PINNED_COUNT, 32'd1);
    write_register(REG_PIN0_NET_ADDR, 32'hFFFF_FFFF);
    write_register(REG_PIN0_LINK_ADDR, 32'h0000_FFFF);
    write_register(REG_PIN0_VLAN, 32'h0000_00FF);
    write_register(REG_PIN1_NET_ADDR, $urandom);
    write_register(REG_PIN1_LINK_ADDR, $urandom);
    write_register(REG_PIN1_VLAN, $urandom);
    write_register(REG_UNUSED, 32'hFFFF_FFFF);
    build_pool(POOL_MAX);
    send_gap_pct = 31;
    queue_random_traffic(RANDOM_ITEMS);
    wait_drained();

    // count of three behaves as two, all-zero pin 0
    write_register(REG_PINNED_COUNT, 32'd3);
    write_register(REG_PIN0_NET_ADDR, 32'd0);
    write_register(REG_PIN0_LINK_ADDR, 32'd0);
    write_register(REG_PIN0_VLAN, 32'd0);
    write_register(REG_PIN1_NET_ADDR, 32'h0000_0001);
    write_register(REG_PIN1_LINK_ADDR, $urandom);
    write_register(REG_PIN1_VLAN, $urandom);
    build_pool(12);
    send_gap_pct = 53;
    queue_random_traffic(RANDOM_ITEMS);
    wait_drained();

    // no pinned entries at all
    write_register(REG_PINNED_COUNT, 32'd0);
    write_register(REG_PIN0_NET_ADDR, $urandom);
    write_register(REG_PIN1_NET_ADDR, 32'hFFFF_FFFF);
    build_pool(20);
    send_gap_pct = 0;
    queue_random_traffic(RANDOM_ITEMS);
    wait_drained();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // command driver, predicts each accepted word
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        answer_q.push_back(predict_answer(cmd_q[0]));
        void'(cmd_q.pop_front());
      end
      if (!start || !busy) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          start     <= 1'b1;
          action    <= cmd_q[0].action;
          net_addr  <= cmd_q[0].net_addr;
          link_addr <= cmd_q[0].link_addr;
          vlan_tag  <= cmd_q[0].vlan_tag;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result word hit=%0b link=%h vlan=%h",
                 $time, hit, found_link_addr, found_vlan);
        errors++;
      end else begin
        exp_a = answer_q.pop_front();
        if (hit !== exp_a.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_a.hit, hit);
          errors++;
        end
        if (found_link_addr !== exp_a.link_addr) begin
          $display("%0t: found_link_addr expected %h actual %h",
                   $time, exp_a.link_addr, found_link_addr);
          errors++;
        end
        if (found_vlan !== exp_a.vlan) begin
          $display("%0t: found_vlan expected %h actual %h",
                   $time, exp_a.vlan, found_vlan);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
